// ===== hw/rtl/lzhe_pkg.sv =====
package lzhe_pkg;

   localparam int CODE_BITS       = 15;
   localparam int LEN_BITS        = 4;
   localparam int ENTRY_BITS      = CODE_BITS + LEN_BITS;

   localparam int MAX_MATCH_LEN   = 258;
   localparam int MAX_DISTANCE    = 32768;

   localparam int DIRECT_LEN_SYMS = 18;
   localparam int LEN_TIER_BASE   = 21;
   localparam int DIST_ALIGN      = 13;
   localparam int DIRECT_DISTS    = 16;
   localparam int MIN_MATCH       = 4;
   localparam int LEN_SYM_OFFSET  = 257;
   localparam int MAX_LITERAL     = 256;

   typedef enum logic [1:0] {
      OP_LOAD_LITLEN = 2'd0,
      OP_LOAD_DIST   = 2'd1,
      OP_ENC_LITERAL = 2'd2,
      OP_ENC_MATCH   = 2'd3
   } opcode_type;

   typedef logic [ENTRY_BITS-1:0] entry_type;

   // what the chunk sequencer needs besides the two table entries
   typedef struct packed {
      logic       is_match;
      logic       bad;
      logic [7:0] lx_val;
      logic [3:0] lx_len;
      logic [14:0] dx_val;
      logic [3:0] dx_len;
   } token_type;

   // index of the highest set bit, zero for zero
   function automatic logic [3:0] top_bit(input logic [15:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) begin
            n = 4'(i);
         end
      end
      return n;
   endfunction

   // code bits of an entry with everything above its length cleared
   function automatic logic [CODE_BITS-1:0] code_mask(input entry_type e);
      logic [LEN_BITS-1:0]  len;
      logic [CODE_BITS:0]   mask;
      len  = e[ENTRY_BITS-1:CODE_BITS];
      mask = (16'd1 << len) - 16'd1;
      return e[CODE_BITS-1:0] & mask[CODE_BITS-1:0];
   endfunction

endpackage

// ===== hw/rtl/lzhe_token_map.sv =====
module lzhe_token_map #(
   parameter int LITLEN_SYMBOLS = 283,
   parameter int DIST_SYMBOLS   = 42,
   localparam int LA = $clog2(LITLEN_SYMBOLS),
   localparam int DA = $clog2(DIST_SYMBOLS)
) (
   input  lzhe_pkg::opcode_type opcode,
   input  logic [8:0]           literal_value,
   input  logic [8:0]           match_length,
   input  logic [15:0]          match_distance,
   output lzhe_pkg::token_type  token,
   output logic [LA-1:0]        lit_addr,
   output logic [DA-1:0]        dist_addr
);

   logic [8:0]  w;
   logic [3:0]  k;
   logic [8:0]  kmask;
   logic [8:0]  lsym;
   logic [15:0] v;
   logic [3:0]  m;
   logic [3:0]  dxl;
   logic [15:0] dmask;
   logic [5:0]  dsym;
   logic        len_bad;
   logic        dist_bad;
   logic        lit_bad;
   logic        sym_bad;

   always_comb begin
      token = '0;
      token.is_match = (opcode == lzhe_pkg::OP_ENC_MATCH);

      // length tiers: base 21 + 2^k with k extra bits
      w     = match_length - 9'(lzhe_pkg::LEN_TIER_BASE);
      k     = lzhe_pkg::top_bit(16'(w));
      kmask = (9'd1 << k) - 9'd1;
      if (32'(match_length) <= lzhe_pkg::DIRECT_LEN_SYMS + lzhe_pkg::MIN_MATCH) begin
         lsym         = 9'(match_length - 9'(lzhe_pkg::MIN_MATCH)
                           + 9'(lzhe_pkg::LEN_SYM_OFFSET));
         token.lx_len = 4'd0;
         token.lx_val = 8'd0;
      end else begin
         lsym         = 9'(k) + 9'(lzhe_pkg::DIRECT_LEN_SYMS + lzhe_pkg::LEN_SYM_OFFSET);
         token.lx_len = k;
         token.lx_val = w[7:0] & kmask[7:0];
      end

      // distance tiers: two symbols per power of two of dist - 13
      v     = match_distance - 16'(lzhe_pkg::DIST_ALIGN);
      m     = lzhe_pkg::top_bit(v);
      dxl   = m - 4'd1;
      dmask = (16'd1 << dxl) - 16'd1;
      if (32'(match_distance) <= lzhe_pkg::DIRECT_DISTS) begin
         dsym         = 6'(match_distance - 16'd1);
         token.dx_len = 4'd0;
         token.dx_val = 15'd0;
      end else begin
         dsym         = 6'({m, 1'b0}) + 6'(lzhe_pkg::DIRECT_DISTS - 4) + 6'(v[dxl]);
         token.dx_len = dxl;
         token.dx_val = 15'(v & dmask);
      end

      len_bad  = (32'(match_length) < lzhe_pkg::MIN_MATCH)
               || (32'(match_length) > lzhe_pkg::MAX_MATCH_LEN);
      dist_bad = (match_distance == 16'd0)
               || (32'(match_distance) > lzhe_pkg::MAX_DISTANCE);
      sym_bad  = (32'(lsym) >= LITLEN_SYMBOLS) || (32'(dsym) >= DIST_SYMBOLS);
      lit_bad  = (32'(literal_value) > lzhe_pkg::MAX_LITERAL)
               || (32'(literal_value) >= LITLEN_SYMBOLS);

      token.bad = token.is_match ? (len_bad || dist_bad || sym_bad) : lit_bad;

      lit_addr  = token.is_match ? lsym[LA-1:0] : literal_value[LA-1:0];
      dist_addr = dsym[DA-1:0];
   end

endmodule

// ===== hw/rtl/lzhe_code_tables.sv =====
module lzhe_code_tables #(
   parameter int LITLEN_SYMBOLS = 283,
   parameter int DIST_SYMBOLS   = 42,
   localparam int LA = $clog2(LITLEN_SYMBOLS),
   localparam int DA = $clog2(DIST_SYMBOLS)
) (
   input  logic                clock,
   input  logic                lit_wr_en,
   input  logic [LA-1:0]       lit_wr_addr,
   input  logic                dist_wr_en,
   input  logic [DA-1:0]       dist_wr_addr,
   input  lzhe_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [LA-1:0]       lit_rd_addr,
   input  logic [DA-1:0]       dist_rd_addr,
   output lzhe_pkg::entry_type lit_rd_data,
   output lzhe_pkg::entry_type dist_rd_data
);

   lzhe_pkg::entry_type lit_mem  [LITLEN_SYMBOLS];
   lzhe_pkg::entry_type dist_mem [DIST_SYMBOLS];
   lzhe_pkg::entry_type lit_rd_ff;
   lzhe_pkg::entry_type dist_rd_ff;

   always_ff @(posedge clock) begin
      if (lit_wr_en) begin
         lit_mem[lit_wr_addr] <= wr_data;
      end
      if (rd_en) begin
         lit_rd_ff <= lit_mem[lit_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dist_wr_en) begin
         dist_mem[dist_wr_addr] <= wr_data;
      end
      if (rd_en) begin
         dist_rd_ff <= dist_mem[dist_rd_addr];
      end
   end

   assign lit_rd_data  = lit_rd_ff;
   assign dist_rd_data = dist_rd_ff;

endmodule

// ===== hw/rtl/lzhe_chunk_emit.sv =====
module lzhe_chunk_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  lzhe_pkg::token_type token,
   input  lzhe_pkg::entry_type lit_entry,
   input  lzhe_pkg::entry_type dist_entry,
   output logic                ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [14:0]         rsp_chunk_bits,
   output logic [3:0]          rsp_chunk_len,
   output logic                rsp_last_chunk,
   output logic                rsp_bad_token
);

   logic                s1_valid_ff, s1_valid_in;
   logic [1:0]          idx_ff, idx_in;
   lzhe_pkg::token_type tok_ff, tok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [14:0]         bits_ff, bits_in;
   logic [3:0]          len_ff, len_in;
   logic                last_ff, last_in;
   logic                bad_ff, bad_in;

   logic        out_free;
   logic        take;
   logic        finish;
   logic        chunk_last;
   logic [14:0] chunk_bits;
   logic [3:0]  chunk_len;

   always_comb begin
      chunk_last = tok_ff.bad || !tok_ff.is_match || (idx_ff == 2'd3);
      case (idx_ff)
         2'd0: begin
            chunk_bits = lzhe_pkg::code_mask(lit_entry);
            chunk_len  = lit_entry[lzhe_pkg::ENTRY_BITS-1:lzhe_pkg::CODE_BITS];
         end
         2'd1: begin
            chunk_bits = 15'(tok_ff.lx_val);
            chunk_len  = tok_ff.lx_len;
         end
         2'd2: begin
            chunk_bits = lzhe_pkg::code_mask(dist_entry);
            chunk_len  = dist_entry[lzhe_pkg::ENTRY_BITS-1:lzhe_pkg::CODE_BITS];
         end
         2'd3: begin
            chunk_bits = tok_ff.dx_val;
            chunk_len  = tok_ff.dx_len;
         end
         default: begin
            chunk_bits = 15'd0;
            chunk_len  = 4'd0;
         end
      endcase
      if (tok_ff.bad) begin
         chunk_bits = 15'd0;
         chunk_len  = 4'd0;
      end

      // output register frees as its word is taken, so a word moves every cycle while rsp_stall is low
      out_free = !rsp_valid_ff || !rsp_stall;
      take     = s1_valid_ff && out_free;
      finish   = take && chunk_last;
      ready    = !s1_valid_ff || finish;

      s1_valid_in = load ? 1'b1 : (finish ? 1'b0 : s1_valid_ff);
      tok_in      = load ? token : tok_ff;
      if (load) begin
         idx_in = 2'd0;
      end else if (take) begin
         idx_in = chunk_last ? 2'd0 : idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end

      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      bits_in      = take ? chunk_bits : bits_ff;
      len_in       = take ? chunk_len : len_ff;
      last_in      = take ? chunk_last : last_ff;
      bad_in       = take ? tok_ff.bad : bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      bits_ff <= bits_in;
      len_ff  <= len_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_chunk_bits = bits_ff;
   assign rsp_chunk_len  = len_ff;
   assign rsp_last_chunk = last_ff;
   assign rsp_bad_token  = bad_ff;

endmodule

// ===== hw/rtl/lz_token_huffman_encoder_unit.sv =====
// LZ77 token encoder with canonical Huffman tables. Load words (opcodes 0 and 1)
// write one code entry into the literal/length or distance table and give no
// output; load a table entry before any token uses it, since an unwritten entry
// reads as garbage. An encoded literal gives one output word, a match gives four
// (length code, length extra bits, distance code, distance extra bits), and a
// token out of range gives one word flagged bad. The output sequencer sends one
// word per cycle while rsp_stall is low, so a literal occupies it for one word and a
// match for four; the next token is taken in the cycle its predecessor's last word
// leaves, giving one literal per cycle when not stalled. The first word of a token
// passes the table read register, filled at the accepting edge, and then the output
// register, which it enters once that register is free.
module lz_token_huffman_encoder_unit #(
   parameter int LITLEN_SYMBOLS = 283,
   parameter int DIST_SYMBOLS   = 42
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [8:0]  req_entry_index,
   input  logic [14:0] req_entry_code,
   input  logic [3:0]  req_entry_len,
   input  logic [8:0]  req_literal_value,
   input  logic [8:0]  req_match_length,
   input  logic [15:0] req_match_distance,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_chunk_bits,
   output logic [3:0]  rsp_chunk_len,
   output logic        rsp_last_chunk,
   output logic        rsp_bad_token
);

   localparam int LA = $clog2(LITLEN_SYMBOLS);
   localparam int DA = $clog2(DIST_SYMBOLS);

   lzhe_pkg::opcode_type op;
   lzhe_pkg::token_type  token;
   lzhe_pkg::entry_type  lit_entry;
   lzhe_pkg::entry_type  dist_entry;
   logic [LA-1:0]        lit_addr;
   logic [DA-1:0]        dist_addr;
   logic                 emit_ready;
   logic                 accept;
   logic                 enc_accept;
   logic                 lit_wr_en;
   logic                 dist_wr_en;

   assign op         = lzhe_pkg::opcode_type'(req_opcode);
   assign req_stall  = !emit_ready;
   assign accept     = req_valid && emit_ready;
   assign enc_accept = accept && (op == lzhe_pkg::OP_ENC_LITERAL
                                  || op == lzhe_pkg::OP_ENC_MATCH);
   // loads beyond a table's depth are dropped
   assign lit_wr_en  = accept && (op == lzhe_pkg::OP_LOAD_LITLEN)
                     && (32'(req_entry_index) < LITLEN_SYMBOLS);
   assign dist_wr_en = accept && (op == lzhe_pkg::OP_LOAD_DIST)
                     && (32'(req_entry_index) < DIST_SYMBOLS);

   lzhe_token_map #(
      .LITLEN_SYMBOLS (LITLEN_SYMBOLS),
      .DIST_SYMBOLS   (DIST_SYMBOLS)
   ) u_map (
      .opcode         (op),
      .literal_value  (req_literal_value),
      .match_length   (req_match_length),
      .match_distance (req_match_distance),
      .token          (token),
      .lit_addr       (lit_addr),
      .dist_addr      (dist_addr)
   );

   lzhe_code_tables #(
      .LITLEN_SYMBOLS (LITLEN_SYMBOLS),
      .DIST_SYMBOLS   (DIST_SYMBOLS)
   ) u_tables (
      .clock        (clock),
      .lit_wr_en    (lit_wr_en),
      .lit_wr_addr  (req_entry_index[LA-1:0]),
      .dist_wr_en   (dist_wr_en),
      .dist_wr_addr (req_entry_index[DA-1:0]),
      .wr_data      ({req_entry_len, req_entry_code}),
      .rd_en        (enc_accept),
      .lit_rd_addr  (lit_addr),
      .dist_rd_addr (dist_addr),
      .lit_rd_data  (lit_entry),
      .dist_rd_data (dist_entry)
   );

   lzhe_chunk_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (enc_accept),
      .token          (token),
      .lit_entry      (lit_entry),
      .dist_entry     (dist_entry),
      .ready          (emit_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_chunk_bits (rsp_chunk_bits),
      .rsp_chunk_len  (rsp_chunk_len),
      .rsp_last_chunk (rsp_last_chunk),
      .rsp_bad_token  (rsp_bad_token)
   );

endmodule
